// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/hocb_pkg.sv =====
// Package with types and constants of the occurrence chain builder.
`default_nettype none
package hocb_pkg;
    localparam int NUM_BUCKETS  = 8192;
    localparam int SLOT_W       = 13;
    localparam int KEY_W        = 31;
    localparam int IDX_W        = 20;
    localparam int CNT_W        = 21;
    localparam int NXT_W        = 21;
    localparam int PROBE_LIMIT  = 8;
    localparam logic [NXT_W-1:0] MAX_ELEMENTS = 21'd1048576;
    localparam logic [CNT_W-1:0] CNT_MAX = 21'h1FFFFF;

    localparam logic [2:0] ST_FIRST   = 3'd0;
    localparam logic [2:0] ST_APPEND  = 3'd1;
    localparam logic [2:0] ST_DROP    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0] idx;
        logic [3:0]       probes;
    } t_cmd;

    typedef struct packed {
        logic [2:0]        status;
        logic [IDX_W-1:0]  elem_index;
        logic [IDX_W-1:0]  prev_index;
        logic [SLOT_W-1:0] bucket_slot;
        logic              slot_used;
        logic [KEY_W-1:0]  slot_key;
        logic [IDX_W-1:0]  slot_first;
        logic [CNT_W-1:0]  collisions;
    } t_res;
endpackage
`default_nettype wire

// ===== hw/rtl/hocb_in_if.sv =====
// Channel interfaces for items and results.
`default_nettype none
interface hocb_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [30:0] key;
    logic        skip;
    logic [12:0] slot;
    modport source (output valid, action, key, skip, slot, input ready);
    modport sink (input valid, action, key, skip, slot, output ready);
endinterface

interface hocb_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [19:0] elem_index;
    logic [19:0] prev_index;
    logic [12:0] bucket_slot;
    logic        slot_used;
    logic [30:0] slot_key;
    logic [19:0] slot_first;
    logic [20:0] collisions;
    modport source (output valid, status, elem_index, prev_index, bucket_slot, slot_used,
        slot_key, slot_first, collisions, input ready);
    modport sink (input valid, status, elem_index, prev_index, bucket_slot, slot_used,
        slot_key, slot_first, collisions, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hocb_front.sv =====
// Front end: accepts items, drops skipped inserts, assigns element indexes.
`default_nettype none
module hocb_front import hocb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hocb_in_if.sink    in_ch,
    input  wire logic [3:0] i_max_probe,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  wire logic  i_cmd_ready
);
    logic [NXT_W-1:0] r_next;
    logic [NXT_W-1:0] n_next;
    logic [3:0] w_probes;
    logic w_take;

    assign in_ch.ready = i_cmd_ready;
    assign w_take = in_ch.valid && i_cmd_ready;

    always_comb begin
        if (i_max_probe == 4'd0) begin
            w_probes = 4'd1;
        end else if (i_max_probe > 4'(PROBE_LIMIT)) begin
            w_probes = 4'(PROBE_LIMIT);
        end else begin
            w_probes = i_max_probe;
        end
        o_cmd.key = in_ch.key;
        o_cmd.slot = in_ch.slot;
        o_cmd.idx = r_next[IDX_W-1:0];
        o_cmd.probes = w_probes;
        n_next = r_next;
        if (in_ch.action) begin
            o_cmd.op = OP_READ;
        end else if (r_next >= MAX_ELEMENTS) begin
            o_cmd.op = OP_FULL;
        end else begin
            o_cmd.op = OP_INSERT;
            if (w_take && !in_ch.skip) begin
                n_next = r_next + 1'b1;
            end
        end
        o_cmd_valid = in_ch.valid && (in_ch.action || !in_ch.skip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next <= '0;
        end else begin
            r_next <= n_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hocb_queue.sv =====
// Two-entry command queue between front and back end.
`default_nettype none
module hocb_queue import hocb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_cmd      i_cmd,
    output logic      o_ready,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_ready
);
    t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd = r_mem[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hocb_back.sv =====
// Back end: bucket table probing sequencer with cleared-at-reset valid memory.
`default_nettype none
module hocb_back import hocb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_cmd      i_cmd,
    output logic      o_ready,
    output logic      o_res_valid,
    output t_res      o_res,
    input  wire logic i_res_ready
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // Entry: valid, key, first, last.
    localparam int ENT_W = 1 + KEY_W + 2*IDX_W;
    logic [ENT_W-1:0] r_mem [NUM_BUCKETS];
    logic [ENT_W-1:0] r_rd;

    logic [2:0] r_state;
    logic [SLOT_W-1:0] r_clr;
    t_cmd r_cmd;
    logic [SLOT_W-1:0] r_h;
    logic [3:0] r_left;
    logic [CNT_W-1:0] r_coll;
    t_res r_res;
    logic r_res_valid;

    logic w_we;
    logic [SLOT_W-1:0] w_wa;
    logic [ENT_W-1:0] w_wd;
    logic [SLOT_W-1:0] w_ra;
    logic w_v;
    logic [KEY_W-1:0] w_k;
    logic [IDX_W-1:0] w_f, w_l;

    assign {w_v, w_k, w_f, w_l} = r_rd;
    assign o_ready = (r_state == S_IDLE) && !r_res_valid;
    assign o_res_valid = r_res_valid;
    assign o_res = r_res;
    assign w_ra = (r_state == S_IDLE) ? (i_cmd.op == OP_READ ? i_cmd.slot
        : i_cmd.key[SLOT_W-1:0]) : r_h;

    always_comb begin
        w_we = 1'b0;
        w_wa = r_h;
        w_wd = {1'b1, r_cmd.key, r_cmd.idx, r_cmd.idx};
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
            w_wa = r_clr;
            w_wd = '0;
        end else if (r_state == S_CHK && r_cmd.op == OP_INSERT) begin
            if (!w_v) begin
                w_we = 1'b1;
            end else if (w_k == r_cmd.key) begin
                w_we = 1'b1;
                w_wd = {1'b1, w_k, w_f, r_cmd.idx};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_coll <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SLOT_W'(NUM_BUCKETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd <= i_cmd;
                        r_h <= w_ra;
                        r_left <= i_cmd.probes;
                        if (i_cmd.op == OP_FULL) begin
                            r_res <= {ST_FULL, {($bits(t_res) - 3 - CNT_W){1'b0}}, r_coll};
                            r_res_valid <= 1'b1;
                        end else begin
                            r_res <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (r_cmd.op == OP_READ) begin
                        r_res.status <= ST_READ;
                        r_res.bucket_slot <= r_h;
                        r_res.slot_used <= w_v;
                        r_res.slot_key <= w_v ? w_k : '0;
                        r_res.slot_first <= w_v ? w_f : '0;
                        r_res.collisions <= r_coll;
                        r_state <= S_OUT;
                    end else if (!w_v) begin
                        r_res.status <= ST_FIRST;
                        r_res.elem_index <= r_cmd.idx;
                        r_res.bucket_slot <= r_h;
                        r_res.collisions <= r_coll;
                        r_state <= S_OUT;
                    end else if (w_k == r_cmd.key) begin
                        r_res.status <= ST_APPEND;
                        r_res.elem_index <= r_cmd.idx;
                        r_res.prev_index <= w_l;
                        r_res.bucket_slot <= r_h;
                        r_res.collisions <= r_coll;
                        r_state <= S_OUT;
                    end else if (r_left == 4'd1) begin
                        r_res.status <= ST_DROP;
                        r_res.elem_index <= r_cmd.idx;
                        r_res.collisions <= (r_coll != CNT_MAX) ? r_coll + 1'b1 : r_coll;
                        if (r_coll != CNT_MAX) begin
                            r_coll <= r_coll + 1'b1;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_h <= r_h + 1'b1;
                        r_left <= r_left - 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    r_res_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hash_occurrence_chain_builder_core.sv =====
// Top level of the hash occurrence chain builder.
// The bucket sequencer takes one command at a time. An insert probes slot after slot, each
// probe a registered memory read followed by a compare, until a free or matching slot is
// found or the probes run out; a read checks one slot and an insert into a full store reads
// none. The next command is taken only after the result has left. After reset a clearing
// pass sweeps all 8192 buckets before the sequencer takes commands.
// max_probe lies at byte address 0 of the APB port.
`default_nettype none
module hash_occurrence_chain_builder_core import hocb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hocb_in_if.sink    in_ch,
    hocb_out_if.source out_ch,
    input  wire logic  psel,
    input  wire logic  penable,
    input  wire logic  pwrite,
    input  wire logic [0:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    logic [3:0] r_max_probe;
    logic w_fv, w_fr, w_bv, w_br;
    t_cmd w_fc, w_bc;
    t_res w_res;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {28'd0, r_max_probe} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_probe <= 4'd8;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            r_max_probe <= pwdata[3:0];
        end
    end

    hocb_front u_front (.i_clk, .i_rst_n, .in_ch, .i_max_probe(r_max_probe),
        .o_cmd_valid(w_fv), .o_cmd(w_fc), .i_cmd_ready(w_fr));
    hocb_queue u_queue (.i_clk, .i_rst_n, .i_valid(w_fv), .i_cmd(w_fc), .o_ready(w_fr),
        .o_valid(w_bv), .o_cmd(w_bc), .i_ready(w_br));
    hocb_back u_back (.i_clk, .i_rst_n, .i_valid(w_bv), .i_cmd(w_bc), .o_ready(w_br),
        .o_res_valid(out_ch.valid), .o_res(w_res), .i_res_ready(out_ch.ready));

    assign out_ch.status = w_res.status;
    assign out_ch.elem_index = w_res.elem_index;
    assign out_ch.prev_index = w_res.prev_index;
    assign out_ch.bucket_slot = w_res.bucket_slot;
    assign out_ch.slot_used = w_res.slot_used;
    assign out_ch.slot_key = w_res.slot_key;
    assign out_ch.slot_first = w_res.slot_first;
    assign out_ch.collisions = w_res.collisions;
endmodule
`default_nettype wire

// ===== hw/rtl/hocb_checker.sv =====
// Port-level checker for the occurrence chain builder and its bind.
`default_nettype none
`include "assert_macros.svh"
module hocb_checker import hocb_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_ovalid,
    input wire logic i_oready,
    input wire logic [2:0] i_status,
    input wire logic [20:0] i_coll,
    input wire logic [19:0] i_prev
);
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_ovalid && !i_oready, i_ovalid && $stable(i_status))
    `ASSERT_IMPLIES(a_code, i_clk, i_rst_n, i_ovalid, i_status <= ST_READ)
    `ASSERT_IMPLIES(a_prev, i_clk, i_rst_n, i_ovalid && i_status != ST_APPEND, i_prev == 20'd0)
    `ASSERT_NEXT(a_coll, i_clk, i_rst_n, i_ovalid && !i_oready, $stable(i_coll) && $stable(i_prev))
endmodule

bind hash_occurrence_chain_builder_core hocb_checker u_chk (.i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_ovalid(out_ch.valid), .i_oready(out_ch.ready), .i_status(out_ch.status),
    .i_coll(out_ch.collisions), .i_prev(out_ch.prev_index));
`default_nettype wire
